[hw/rtl/mtfal_pkg.sv]
package mtfal_pkg;

   // default sizing of the tree
   localparam int LEAVES_DEFAULT     = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // fixed port widths
   localparam int COUNT_WIDTH = 11;
   localparam int INDEX_WIDTH = 10;
   localparam int VALUE_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 11'd1024;

   // transaction kinds
   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_FIND = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_WR,
      ST_SET_RD,
      ST_FIND
   } state_type;

   // one result transaction
   typedef struct packed {
      logic                   valid;
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
   } rsp_type;

endpackage

[hw/rtl/mtfal_node_ram.sv]
module mtfal_node_ram import mtfal_pkg::*; #(
   parameter int ADDR_WIDTH = $clog2(LEAVES_DEFAULT) + 1,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_WIDTH-1:0]        wr_addr,
   input  logic signed [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0]        rd_addr,
   output logic signed [DATA_WIDTH-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_WIDTH;

   logic signed [DATA_WIDTH-1:0] node_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mtfal_ctrl.sv]
module mtfal_ctrl import mtfal_pkg::*; #(
   parameter int LEAVES     = LEAVES_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int ADDR_WIDTH = $clog2(LEAVES_DEFAULT) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [INDEX_WIDTH-1:0]        req_position,
   input  logic signed [VALUE_WIDTH-1:0] req_new_value,
   input  logic signed [VALUE_WIDTH-1:0] req_threshold,
   input  logic [INDEX_WIDTH-1:0]        req_start_index,
   input  logic [COUNT_WIDTH-1:0]        count,
   output rsp_type                       rsp,
   output logic                          wr_en,
   output logic [ADDR_WIDTH-1:0]         wr_addr,
   output logic signed [DATA_WIDTH-1:0]  wr_data,
   output logic [ADDR_WIDTH-1:0]         rd_addr,
   input  logic signed [DATA_WIDTH-1:0]  rd_data
);

   localparam int LEVELS = ADDR_WIDTH - 1;
   localparam int AW     = ADDR_WIDTH;
   localparam int CW     = (DATA_WIDTH > VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;
   localparam int CMPW   = (AW > COUNT_WIDTH) ? AW : COUNT_WIDTH;
   localparam logic [AW-1:0] LEAF_BASE = {1'b1, {LEVELS{1'b0}}};
   localparam logic [AW-1:0] ROOT      = AW'(1);
   localparam logic [AW-1:0] CLR_LAST  = '1;

   // drop the trailing zeros: from a failed node to the next subtree on its right
   function automatic logic [AW:0] strip_zeros(input logic [AW:0] m);
      logic [AW:0] r;
      logic [AW:0] ones;
      r    = m;
      ones = '1;
      for (int i = 1; i <= AW; i++) begin
         if ((m & ~(ones << i)) == '0) begin
            r = m >> i;
         end
      end
      return r;
   endfunction

   state_type               state_ff, state_in;
   logic [AW-1:0]           cur_ff, cur_in;
   logic signed [DATA_WIDTH-1:0] val_ff, val_in;
   logic signed [CW-1:0]    thr_ff, thr_in;
   logic                    down_ff, down_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic                    is_set;
   logic                    pos_ok;
   logic                    start_ok;
   logic [AW-1:0]           set_leaf;
   logic [AW-1:0]           start_leaf;
   logic signed [CW-1:0]    nv_ext;
   logic signed [CW-1:0]    node_val;
   logic                    hit;
   logic                    do_desc;
   logic [AW-1:0]           desc_node;
   logic                    leaf_hit;
   logic [AW-1:0]           child;
   logic [AW:0]             climb;
   logic                    exhausted;
   logic [LEVELS-1:0]       found_idx;
   logic                    found_ok;
   logic                    find_done;

   // request decode
   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      is_set     = (req_kind == KIND_SET);
      pos_ok     = (CMPW'(req_position) < CMPW'(count)) &&
                   (CMPW'(req_position) < CMPW'(LEAVES));
      start_ok   = CMPW'(req_start_index) < CMPW'(LEAVES);
      set_leaf   = LEAF_BASE | AW'(req_position);
      start_leaf = LEAF_BASE | AW'(req_start_index);
      nv_ext     = CW'(req_new_value);
   end

   // one search step per cycle on the node read last cycle
   always_comb begin
      node_val  = CW'(rd_data);
      hit       = node_val >= thr_ff;
      do_desc   = hit || down_ff;
      desc_node = hit ? cur_ff : (cur_ff | AW'(1));
      leaf_hit  = desc_node[AW-1];
      child     = {desc_node[AW-2:0], 1'b0};
      climb     = strip_zeros({1'b0, cur_ff} + (AW+1)'(1));
      exhausted = (climb == (AW+1)'(1));
      found_idx = desc_node[LEVELS-1:0];
      found_ok  = (CMPW'(found_idx) < CMPW'(count)) &&
                  (CMPW'(found_idx) < CMPW'(LEAVES));
      find_done = do_desc ? leaf_hit : exhausted;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cur_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_set && pos_ok) begin
                  state_in = ST_SET_WR;
               end else if (!is_set && start_ok) begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_SET_WR: begin
            state_in = (cur_ff == ROOT) ? ST_IDLE : ST_SET_RD;
         end
         ST_SET_RD: state_in = ST_SET_WR;
         ST_FIND: begin
            if (find_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cur_in  = cur_ff;
      val_in  = val_ff;
      thr_in  = thr_ff;
      down_in = down_ff;
      rsp_in  = '0;
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = val_ff;
      rd_addr = cur_ff;
      case (state_ff)
         // zero every node after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            cur_in  = cur_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_set) begin
                  cur_in       = set_leaf;
                  val_in       = nv_ext[DATA_WIDTH-1:0];
                  rsp_in.valid = !pos_ok;
               end else begin
                  cur_in       = start_leaf;
                  rd_addr      = start_leaf;
                  thr_in       = CW'(req_threshold);
                  down_in      = 1'b0;
                  rsp_in.valid = !start_ok;
               end
            end
         end
         // write the node, fetch its sibling
         ST_SET_WR: begin
            wr_en        = 1'b1;
            rd_addr      = cur_ff ^ AW'(1);
            rsp_in.valid = (cur_ff == ROOT);
         end
         // parent takes the larger of the pair
         ST_SET_RD: begin
            val_in = (rd_data > val_ff) ? rd_data : val_ff;
            cur_in = cur_ff >> 1;
         end
         ST_FIND: begin
            if (do_desc) begin
               if (leaf_hit) begin
                  rsp_in.valid = 1'b1;
                  rsp_in.found = found_ok;
                  rsp_in.index = found_ok ? INDEX_WIDTH'(found_idx) : '0;
               end else begin
                  cur_in  = child;
                  rd_addr = child;
                  down_in = 1'b1;
               end
            end else begin
               if (exhausted) begin
                  rsp_in.valid = 1'b1;
               end else begin
                  cur_in  = climb[AW-1:0];
                  rd_addr = climb[AW-1:0];
                  down_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cur_ff   <= '0;
         down_ff  <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         down_ff  <= down_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      thr_ff <= thr_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

[hw/rtl/max_tree_first_at_least_unit.sv]
// Set: writes the leaf, then walks up to the root, each parent taking the larger of its pair.
// Find: one node read per cycle up and down the tree.
// Out-of-range items answer in the cycle after accept; a new transaction is taken in
// the cycle its predecessor's result is shown. Results cannot be stalled.
// Reset: synchronous; busy stays high while the node memory is cleared, and
// the active count returns to 1024.
module max_tree_first_at_least_unit import mtfal_pkg::*; #(
   parameter int LEAVES     = LEAVES_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [INDEX_WIDTH-1:0]        req_position,
   input  logic signed [VALUE_WIDTH-1:0] req_new_value,
   input  logic signed [VALUE_WIDTH-1:0] req_threshold,
   input  logic [INDEX_WIDTH-1:0]        req_start_index,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [INDEX_WIDTH-1:0]        rsp_result_index,
   input  logic                          csr_wr_en,
   input  logic [COUNT_WIDTH-1:0]        csr_wr_data
);

   localparam int ADDR_WIDTH = $clog2(LEAVES) + 1;

   logic [COUNT_WIDTH-1:0]       count_ff;
   rsp_type                      rsp;
   logic                         wr_en;
   logic [ADDR_WIDTH-1:0]        wr_addr;
   logic signed [DATA_WIDTH-1:0] wr_data;
   logic [ADDR_WIDTH-1:0]        rd_addr;
   logic signed [DATA_WIDTH-1:0] rd_data;

   // active count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   mtfal_ctrl #(
      .LEAVES     (LEAVES),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_threshold   (req_threshold),
      .req_start_index (req_start_index),
      .count           (count_ff),
      .rsp             (rsp),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   mtfal_node_ram #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result transaction
   assign rsp_valid        = rsp.valid;
   assign rsp_found        = rsp.found;
   assign rsp_result_index = rsp.index;

endmodule

[tb/max_tree_first_at_least_unit_tb.sv]
module max_tree_first_at_least_unit_tb import mtfal_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LEAVES  = 1024;
   localparam int CYCLE_LIMIT = 400000;

   // one request transaction as the block sees it
   typedef struct {
      logic                          kind;
      logic [INDEX_WIDTH-1:0]        position;
      logic signed [VALUE_WIDTH-1:0] new_value;
      logic signed [VALUE_WIDTH-1:0] threshold;
      logic [INDEX_WIDTH-1:0]        start_index;
   } tree_op_type;

   // what a transaction should answer
   typedef struct {
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
   } tree_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_kind = KIND_SET;
   logic [INDEX_WIDTH-1:0]        req_position = '0;
   logic signed [VALUE_WIDTH-1:0] req_new_value = '0;
   logic signed [VALUE_WIDTH-1:0] req_threshold = '0;
   logic [INDEX_WIDTH-1:0]        req_start_index = '0;
   logic                          rsp_valid;
   logic                          rsp_found;
   logic [INDEX_WIDTH-1:0]        rsp_result_index;
   logic                          csr_wr_en = 1'b0;
   logic [COUNT_WIDTH-1:0]        csr_wr_data = '0;

   // shadow copy of the array and the active count
   logic signed [VALUE_WIDTH-1:0] tree_elems [0:NUM_LEAVES-1];
   logic [COUNT_WIDTH-1:0]        active_cnt = COUNT_RESET;

   tree_op_type     pending_ops[$];
   tree_answer_type answer_q[$];
   tree_op_type     held_op;

   logic signed [VALUE_WIDTH-1:0] value_pool [0:15];
   int unsigned idle_pct = 0;
   int unsigned ops_sent = 0;
   int unsigned answers_checked = 0;
   int unsigned found_hits = 0;
   int unsigned count_writes = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   max_tree_first_at_least_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_new_value    (req_new_value),
      .req_threshold    (req_threshold),
      .req_start_index  (req_start_index),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   // active count clipped to the tree size
   function automatic int unsigned usable_count(logic [COUNT_WIDTH-1:0] cnt);
      return (cnt > NUM_LEAVES) ? NUM_LEAVES : int'(cnt);
   endfunction

   // apply one transaction to the shadow array and work out its answer
   function automatic tree_answer_type apply_tree_op(tree_op_type op);
      tree_answer_type ans;
      int unsigned     eff;
      int              j;
      bit              hit;
      ans.found = 1'b0;
      ans.index = '0;
      eff = usable_count(active_cnt);
      hit = 1'b0;
      if (op.kind == KIND_SET) begin
         if (op.position < eff)
            tree_elems[op.position] = op.new_value;
      end else begin
         // first element at or after the start that reaches the threshold,
         // counted as a miss when it lies past the active count
         for (j = int'(op.start_index); j < NUM_LEAVES && !hit; j++) begin
            if (tree_elems[j] >= op.threshold) begin
               hit = 1'b1;
               if (j < eff) begin
                  ans.found = 1'b1;
                  ans.index = INDEX_WIDTH'(j);
               end
            end
         end
      end
      return ans;
   endfunction

   // driver: present the next transaction once the current one is taken
   always @(posedge clock) begin : drive_proc
      bit          slot_free;
      tree_op_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         slot_free = !start;
         if (start && !busy) begin
            answer_q.push_back(apply_tree_op(held_op));
            ops_sent++;
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (pending_ops.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
               nxt = pending_ops.pop_front();
               held_op = nxt;
               start <= 1'b1;
               req_kind <= nxt.kind;
               req_position <= nxt.position;
               req_new_value <= nxt.new_value;
               req_threshold <= nxt.threshold;
               req_start_index <= nxt.start_index;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest expected answer
   always @(posedge clock) begin : watch_proc
      tree_answer_type exp_ans;
      if (!reset && rsp_valid === 1'b1) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result found=%0b index=%0d", $time,
                     rsp_found, rsp_result_index);
            errors++;
         end else begin
            exp_ans = answer_q.pop_front();
            answers_checked++;
            if (exp_ans.found) found_hits++;
            if (rsp_found !== exp_ans.found) begin
               $display("%0t: found mismatch, expected %0b actual %0b", $time,
                        exp_ans.found, rsp_found);
               errors++;
            end
            if (rsp_result_index !== exp_ans.index) begin
               $display("%0t: result_index mismatch, expected %0d actual %0d", $time,
                        exp_ans.index, rsp_result_index);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d answers outstanding", $time, answer_q.size());
         $display("[max_tree_first_at_least_unit] ERROR");
         $finish;
      end
   end

   task automatic queue_set(input logic [INDEX_WIDTH-1:0] pos,
                            input logic signed [VALUE_WIDTH-1:0] val);
      tree_op_type op;
      op.kind = KIND_SET;
      op.position = pos;
      op.new_value = val;
      op.threshold = $urandom;
      op.start_index = INDEX_WIDTH'($urandom);
      pending_ops.push_back(op);
   endtask

   task automatic queue_find(input logic signed [VALUE_WIDTH-1:0] thr,
                             input logic [INDEX_WIDTH-1:0] from);
      tree_op_type op;
      op.kind = KIND_FIND;
      op.position = INDEX_WIDTH'($urandom);
      op.new_value = $urandom;
      op.threshold = thr;
      op.start_index = from;
      pending_ops.push_back(op);
   endtask

   // random transaction, values mostly from a small pool so finds land on stored data
   task automatic queue_random_op(input int unsigned eff);
      tree_op_type op;
      int unsigned r;
      op.kind = ($urandom_range(1, 0) == 1) ? KIND_FIND : KIND_SET;
      if ($urandom_range(9, 0) < 8 && eff > 0)
         op.position = INDEX_WIDTH'($urandom_range(eff - 1, 0));
      else
         op.position = INDEX_WIDTH'($urandom);
      op.new_value = ($urandom_range(9, 0) < 7) ? value_pool[$urandom_range(15, 0)]
                                                 : $urandom;
      r = $urandom_range(9, 0);
      if (r < 6)
         op.threshold = value_pool[$urandom_range(15, 0)];
      else if (r < 8)
         op.threshold = value_pool[$urandom_range(15, 0)] + 1;
      else
         op.threshold = $urandom;
      r = $urandom_range(9, 0);
      if (r < 3)
         op.start_index = '0;
      else if (r < 7 && eff > 0)
         op.start_index = INDEX_WIDTH'($urandom_range(eff - 1, 0));
      else
         op.start_index = INDEX_WIDTH'($urandom);
      pending_ops.push_back(op);
   endtask

   // wait until every transaction has been answered, then a little longer
   task automatic wait_drained();
      while (pending_ops.size() != 0 || start === 1'b1 || answer_q.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_count(input logic [COUNT_WIDTH-1:0] cnt);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cnt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_cnt = cnt;
      count_writes++;
   endtask

   initial begin : stim_proc
      int unsigned phase_cnt [0:7];
      int unsigned phase_len;
      int unsigned k;
      int unsigned p;
      for (k = 0; k < NUM_LEAVES; k++)
         tree_elems[k] = '0;
      value_pool[0] = 32'sh0000_0000;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      for (k = 4; k < 16; k++)
         value_pool[k] = $urandom;

      // reset, then let the clearing pass finish
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy !== 1'b0)
         @(negedge clock);

      // directed: extremes on a cleared tree
      idle_pct = 33;
      write_count(11'd1024);
      queue_find(32'sd0, 10'd0);
      queue_find(32'sd1, 10'd0);
      queue_find(32'sh8000_0000, 10'd1023);
      queue_set(10'd0, 32'sh7FFF_FFFF);
      queue_set(10'd1023, 32'sh8000_0000);
      queue_set(10'd5, 32'sh5555_5555);
      queue_set(10'd6, 32'shAAAA_AAAA);
      queue_find(32'sh7FFF_FFFF, 10'd0);
      queue_find(32'sh7FFF_FFFF, 10'd1);
      queue_find(32'sh5555_5555, 10'd1);
      queue_find(32'sh8000_0000, 10'd1023);
      queue_find(32'sd1, 10'd1023);
      wait_drained();

      // directed: set outside the active range, match past the active count
      write_count(11'd7);
      queue_set(10'd7, 32'sd100);
      queue_set(10'd6, 32'sd3);
      queue_find(32'sd100, 10'd1);
      queue_find(32'sh8000_0000, 10'd7);
      wait_drained();

      // directed: zero active count
      write_count(11'd0);
      queue_set(10'd0, 32'sd1);
      queue_find(32'sh8000_0000, 10'd0);
      wait_drained();

      // directed: active count above the tree size
      write_count(11'd2047);
      queue_set(10'd1023, 32'sd9);
      queue_find(32'sd9, 10'd512);
      queue_find(32'sh8000_0000, 10'd1023);
      wait_drained();

      // random phases over several active counts
      phase_cnt[0] = 1024;
      phase_cnt[1] = $urandom_range(1023, 2);
      phase_cnt[2] = 1;
      phase_cnt[3] = 2047;
      phase_cnt[4] = 0;
      phase_cnt[5] = 513;
      phase_cnt[6] = $urandom_range(1024, 1);
      phase_cnt[7] = 1024;
      for (p = 0; p < 8; p++) begin
         idle_pct = (p < 3) ? 33 : (p < 6) ? 88 : 0;
         phase_len = (phase_cnt[p] == 0) ? 30 : 117;
         write_count(COUNT_WIDTH'(phase_cnt[p]));
         for (k = 0; k < phase_len; k++)
            queue_random_op(usable_count(COUNT_WIDTH'(phase_cnt[p])));
         wait_drained();
      end

      $display("%0d transactions sent, %0d results checked (%0d found), %0d count writes",
               ops_sent, answers_checked, found_hits, count_writes);
      if (errors == 0) begin
         $display("[max_tree_first_at_least_unit] OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("[max_tree_first_at_least_unit] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mtfal_pkg.sv
hw/rtl/mtfal_node_ram.sv
hw/rtl/mtfal_ctrl.sv
hw/rtl/max_tree_first_at_least_unit.sv
tb/max_tree_first_at_least_unit_tb.sv
